>>> src/cmdq_pkg.sv
package cmdq_pkg;

  localparam int NUM_PORTS   = 4;
  localparam int CMD_WORDS   = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int IND_COUNT   = 256;

  localparam int PORT_W = $clog2(NUM_PORTS);
  localparam int WSEL_W = $clog2(CMD_WORDS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int IDX_W  = $clog2(IND_COUNT);
  localparam int STG_AW = PORT_W + WSEL_W;
  localparam int Q_AW   = PTR_W + WSEL_W;

  localparam logic [1:0] RT_CPU  = 2'd0;
  localparam logic [1:0] RT_SYNC = 2'd1;
  localparam logic [1:0] RT_RESP = 2'd2;
  localparam logic [1:0] RT_TICK = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_WIN   = 3'd1;
  localparam logic [2:0] ST_BAD_CTRL  = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_BAD_SYNC  = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd6;
  localparam logic [2:0] ST_SIZE      = 3'd7;

  localparam logic [63:0] CTRL_PUSH = 64'd0;
  localparam logic [63:0] CTRL_POP  = 64'd1;

  localparam logic [3:0] DT_SYNC     = 4'h1;
  localparam logic [7:0] OP_WAIT     = 8'h00;
  localparam logic [7:0] OP_SET      = 8'h01;
  localparam logic [3:0] TARGET_HIGH = 4'h7;

  typedef struct packed {
    logic              rd;
    logic [STG_AW-1:0] raddr;
    logic              wr;
    logic [STG_AW-1:0] waddr;
    logic [63:0]       wdata;
    logic              clr;
    logic [PORT_W-1:0] clr_port;
  } stg_req_t;

  typedef struct packed {
    logic             rd;
    logic [IDX_W-1:0] raddr;
    logic             wr;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
  } flag_req_t;

endpackage

>>> src/cmdq_stage.sv
module cmdq_stage import cmdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stg_req_t    req,
  output logic [63:0] rdata
);

  logic [63:0] mem [NUM_PORTS*CMD_WORDS];
  logic [NUM_PORTS*CMD_WORDS-1:0] vld;
  logic [63:0] q;
  logic        q_vld;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      q <= mem[req.raddr];
    end
  end

  // An entry that was never written since reset or since its push reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (req.wr) begin
        vld[req.waddr] <= 1'b1;
      end
      if (req.clr) begin
        vld[req.clr_port*CMD_WORDS +: CMD_WORDS] <= '0;
      end
      if (req.rd) begin
        q_vld <= vld[req.raddr];
      end
    end
  end

  assign rdata = q_vld ? q : 64'd0;

endmodule

>>> src/cmdq_flags.sv
module cmdq_flags import cmdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  flag_req_t req,
  output logic      flag
);

  logic                 mem [IND_COUNT];
  logic [IND_COUNT-1:0] vld;
  logic                 q;
  logic                 q_vld;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (req.wr) begin
        vld[req.waddr] <= 1'b1;
      end
      if (req.rd) begin
        q_vld <= vld[req.raddr];
      end
    end
  end

  assign flag = q & q_vld;

endmodule

>>> src/command_queue_sync_dispatch.sv
// An input word is acknowledged after its decode; a push first copies eight staging
// words through the memories, and each released sync wait passes S_DISP, S_HDR, S_FLAG.
// A dispatch then reads and loads each command word in turn, 8 words per command.
// Throughput: one input word at a time; no new word is taken until all output words
// of the previous one are loaded into the output register (one read port per memory).
// Reset (rst, synchronous) empties the queue, clears staging data and all indicator flags.
module command_queue_sync_dispatch import cmdq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // port[1:0], offset[8:2], size[12:9], data[76:13]
  input  logic [1:0]   s_tuser,   // req_type[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // status[2:0], queue_count[6:3], dest_addr[38:7],
                                  // word_index[41:39], word_data[105:42]
  output logic [0:0]   m_tuser,   // kind[0]
  output logic         m_tlast
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECODE  = 10'b0000000010,
    S_MERGE_A = 10'b0000000100,
    S_MERGE_B = 10'b0000001000,
    S_PUSH    = 10'b0000010000,
    S_DISP    = 10'b0000100000,
    S_HDR     = 10'b0001000000,
    S_FLAG    = 10'b0010000000,
    S_ACK     = 10'b0100000000,
    S_WORD    = 10'b1000000000
  } state_t;

  state_t state;
  logic   emit;   // in S_WORD: read issued, data waits for the output register

  logic [1:0]        rtype;
  logic [PORT_W-1:0] port;
  logic [6:0]        offset;
  logic [3:0]        size;
  logic [63:0]       data;
  logic [2:0]        status;

  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  entry_count;
  logic              push_gate;
  logic              write_pending;
  logic              disp;
  logic [7:0]        hdr_type_id;
  logic [WSEL_W:0]   cnt;

  logic [63:0]       qmem [QUEUE_DEPTH*CMD_WORDS];
  logic [63:0]       qrdata;
  logic              q_rd;
  logic [Q_AW-1:0]   q_raddr;
  logic              q_wr;
  logic [Q_AW-1:0]   q_waddr;

  stg_req_t    sreq;
  flag_req_t   freq;
  logic [63:0] srdata;
  logic        flag;

  logic [63:0]  byte_mask;
  logic [127:0] mask_sh;
  logic [127:0] data_sh;
  logic [7:0]   end_pos;
  logic [63:0]  ctrl;
  logic         sync_ok;
  logic         slot_free;
  logic [3:0]   h_type;
  logic [3:0]   h_id;
  logic [7:0]   h_op;
  logic [7:0]   h_idx;

  logic [2:0]   dec_status;
  state_t       dec_state;
  logic         dec_drop;
  logic         out_load;

  cmdq_stage u_stage (.clk, .rst, .req(sreq), .rdata(srdata));
  cmdq_flags u_flags (.clk, .rst, .req(freq), .flag);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_mask[8*b +: 8] = ({1'b0, size} > 5'(b)) ? 8'hFF : 8'h00;
    end
  end

  assign mask_sh   = {64'd0, byte_mask} << {offset[2:0], 3'b000};
  assign data_sh   = {64'd0, data & byte_mask} << {offset[2:0], 3'b000};
  assign end_pos   = {1'b0, offset} + {4'd0, size};
  assign ctrl      = data & byte_mask;
  assign sync_ok   = (size >= 4'd4) && (size <= 4'd8) && (data[23:16] == OP_SET);
  assign slot_free = !m_tvalid || m_tready;
  assign h_type    = qrdata[63:60];
  assign h_id      = qrdata[59:56];
  assign h_op      = qrdata[55:48];
  assign h_idx     = qrdata[47:40];
  assign s_tready  = (state == S_IDLE);
  assign out_load  = slot_free && ((state == S_ACK) || ((state == S_WORD) && emit));

  // Decode of the captured input word: status, follow-up state and head removal.
  always_comb begin
    dec_status = ST_OK;
    dec_state  = S_DISP;
    dec_drop   = 1'b0;
    case (rtype)
      RT_CPU: begin
        if (size == 4'd0 || size > 4'd8) begin
          dec_status = ST_SIZE;
        end else if (end_pos > 8'd128) begin
          dec_status = ST_BAD_WIN;
        end else if (!offset[6]) begin
          if (end_pos > 8'd64) begin
            dec_status = ST_BAD_WIN;
          end else begin
            dec_state = S_MERGE_A;
          end
        end else if (ctrl == CTRL_PUSH) begin
          if (entry_count >= CNT_W'(QUEUE_DEPTH) || push_gate) begin
            dec_status = ST_BLOCKED;
          end else begin
            dec_state = S_PUSH;
          end
        end else if (ctrl == CTRL_POP) begin
          if (entry_count == '0) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_drop = 1'b1;
          end
        end else begin
          dec_status = ST_BAD_CTRL;
        end
      end
      RT_SYNC: begin
        if (size < 4'd4 || size > 4'd8) begin
          dec_status = ST_SIZE;
        end else if (!sync_ok) begin
          dec_status = ST_BAD_SYNC;
        end
      end
      RT_RESP: begin
        if (!write_pending || entry_count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_drop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sreq          = '0;
    sreq.clr_port = port;
    sreq.wdata    = (srdata & ~mask_sh[63:0]) | data_sh[63:0];
    sreq.raddr    = {port, offset[5:3]};
    sreq.waddr    = {port, offset[5:3]};
    freq          = '0;
    freq.raddr    = h_idx;
    freq.waddr    = data[15:8];
    q_rd          = 1'b0;
    q_raddr       = {head_ptr, cnt[WSEL_W-1:0]};
    q_wr          = 1'b0;
    q_waddr       = {tail_ptr, cnt[WSEL_W-1:0] - 1'b1};
    unique case (state)
      S_DECODE: begin
        sreq.rd    = 1'b1;
        freq.wr    = (rtype == RT_SYNC) && sync_ok;
        freq.wdata = 1'b1;
      end
      S_MERGE_A: begin
        sreq.wr    = 1'b1;
        sreq.rd    = |mask_sh[127:64];
        sreq.raddr = {port, offset[5:3] + 3'd1};
      end
      S_MERGE_B: begin
        sreq.wr    = 1'b1;
        sreq.wdata = (srdata & ~mask_sh[127:64]) | data_sh[127:64];
        sreq.waddr = {port, offset[5:3] + 3'd1};
      end
      S_PUSH: begin
        sreq.rd    = !cnt[WSEL_W];
        sreq.raddr = {port, cnt[WSEL_W-1:0]};
        q_wr       = (cnt != '0);
        sreq.clr   = cnt[WSEL_W];
      end
      S_DISP: begin
        q_rd    = !write_pending && (entry_count != '0);
        q_raddr = {head_ptr, {WSEL_W{1'b1}}};
      end
      S_HDR: begin
        freq.rd = (h_type == DT_SYNC) && (h_op == OP_WAIT);
      end
      S_FLAG: begin
        freq.wr    = flag;
        freq.wdata = 1'b0;
        freq.waddr = h_idx;
      end
      S_WORD: begin
        q_rd = !emit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_wr) begin
      qmem[q_waddr] <= srdata;
    end
    if (q_rd) begin
      qrdata <= qmem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      rtype  <= s_tuser;
      port   <= s_tdata[1:0];
      offset <= s_tdata[8:2];
      size   <= s_tdata[12:9];
      data   <= s_tdata[76:13];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      emit          <= 1'b0;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      entry_count   <= '0;
      push_gate     <= 1'b0;
      write_pending <= 1'b0;
      disp          <= 1'b0;
      cnt           <= '0;
      status        <= ST_OK;
      m_tvalid      <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status <= dec_status;
          state  <= dec_state;
          cnt    <= '0;
          if (dec_drop) begin
            head_ptr    <= head_ptr + 1'b1;
            entry_count <= entry_count - 1'b1;
          end
          if (rtype == RT_RESP) begin
            write_pending <= 1'b0;
          end
          if (rtype == RT_TICK) begin
            push_gate <= 1'b0;
          end
        end
        S_MERGE_A: begin
          state <= (|mask_sh[127:64]) ? S_MERGE_B : S_DISP;
        end
        S_MERGE_B: begin
          state <= S_DISP;
        end
        S_PUSH: begin
          if (cnt[WSEL_W]) begin
            cnt         <= '0;
            tail_ptr    <= tail_ptr + 1'b1;
            entry_count <= entry_count + 1'b1;
            push_gate   <= 1'b1;
            state       <= S_DISP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DISP: begin
          disp  <= 1'b0;
          state <= (!write_pending && (entry_count != '0)) ? S_HDR : S_ACK;
        end
        S_HDR: begin
          hdr_type_id <= {h_type, h_id};
          if ((h_type == DT_SYNC) && (h_op == OP_WAIT)) begin
            state <= S_FLAG;
          end else begin
            disp  <= 1'b1;
            state <= S_ACK;
          end
        end
        S_FLAG: begin
          if (flag) begin
            head_ptr    <= head_ptr + 1'b1;
            entry_count <= entry_count - 1'b1;
            state       <= S_DISP;
          end else begin
            state <= S_ACK;
          end
        end
        S_ACK: begin
          if (slot_free) begin
            m_tuser <= 1'b0;
            m_tlast <= !disp;
            m_tdata <= {6'd0, 64'd0, 3'd0, 32'd0, entry_count, status};
            cnt     <= '0;
            emit    <= 1'b0;
            state   <= disp ? S_WORD : S_IDLE;
          end
        end
        S_WORD: begin
          if (!emit) begin
            emit <= 1'b1;
          end else if (slot_free) begin
            m_tuser <= 1'b1;
            m_tlast <= (cnt == CMD_WORDS - 1);
            m_tdata <= {6'd0, qrdata, cnt[WSEL_W-1:0], TARGET_HIGH, hdr_type_id, 20'd0,
                        entry_count, ST_OK};
            emit    <= 1'b0;
            cnt     <= cnt + 1'b1;
            if (cnt == CMD_WORDS - 1) begin
              write_pending <= 1'b1;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (PTR_W'(tail_ptr - head_ptr) == entry_count[PTR_W-1:0]))
    else $error("pointers disagree with queue count");

  a_no_double_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD) |-> !write_pending)
    else $error("dispatch while a write is outstanding");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cmdq_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  count;
    logic [31:0] addr;
    logic [2:0]  windex;
    logic [63:0] wdata;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  rt;
    logic [1:0]  port;
    logic [6:0]  off;
    logic [3:0]  size;
    logic [63:0] data;
    bit          has_status;
    logic [2:0]  status;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [79:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  command_queue_sync_dispatch u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Shadow copy of the block's state.
  logic [63:0]      stage_mem [NUM_PORTS][CMD_WORDS];
  logic [63:0]      fifo_mem [QUEUE_DEPTH][CMD_WORDS];
  logic [PTR_W-1:0] head_q;
  logic [PTR_W-1:0] tail_q;
  int               fill_q;
  bit               gate_q;
  bit               pending_q;
  bit               flag_q [IND_COUNT];

  result_t expected_words[$];
  int      errors;
  int      items_sent;
  int      words_seen;
  int      cmds_sent;
  int      burst_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [2:0] cpu_access(logic [1:0] port, int off, int size,
                                            logic [63:0] data);
    logic [63:0] ctrl;
    int pos;
    if (size == 0 || size > 8) return ST_SIZE;
    if (port >= NUM_PORTS || off + size > 2 * CMD_WORDS * 8) return ST_BAD_WIN;
    if (off < CMD_WORDS * 8) begin
      if (off + size > CMD_WORDS * 8) return ST_BAD_WIN;
      for (int b = 0; b < size; b++) begin
        pos = off + b;
        stage_mem[port][pos / 8][(pos % 8) * 8 +: 8] = data[8 * b +: 8];
      end
      return ST_OK;
    end
    ctrl = (size == 8) ? data : (data & ((64'd1 << (8 * size)) - 64'd1));
    if (ctrl == CTRL_PUSH) begin
      if (fill_q >= QUEUE_DEPTH || gate_q) return ST_BLOCKED;
      for (int w = 0; w < CMD_WORDS; w++) begin
        fifo_mem[tail_q][w] = stage_mem[port][w];
        stage_mem[port][w] = '0;
      end
      tail_q++;
      fill_q++;
      gate_q = 1;
      return ST_OK;
    end
    if (ctrl == CTRL_POP) begin
      if (fill_q == 0) return ST_EMPTY;
      head_q++;
      fill_q--;
      return ST_OK;
    end
    return ST_BAD_CTRL;
  endfunction

  // Works out the acknowledgment and any dispatched words of one input word.
  task automatic predict_step(row_t r);
    result_t     words[$];
    result_t     one;
    logic [2:0]  st;
    logic [31:0] hw;
    case (r.rt)
      RT_CPU: st = cpu_access(r.port, r.off, r.size, r.data);
      RT_SYNC: begin
        if (r.size < 4 || r.size > 8) st = ST_SIZE;
        else if (r.data[23:16] != OP_SET) st = ST_BAD_SYNC;
        else begin
          flag_q[r.data[15:8]] = 1;
          st = ST_OK;
        end
      end
      RT_RESP: begin
        if (!pending_q) st = ST_EMPTY;
        else begin
          pending_q = 0;
          if (fill_q == 0) st = ST_EMPTY;
          else begin
            head_q++;
            fill_q--;
            st = ST_OK;
          end
        end
      end
      default: begin
        gate_q = 0;
        st = ST_OK;
      end
    endcase
    if (r.has_status) st = r.status;
    one = '{1'b0, st, 4'd0, 32'd0, 3'd0, 64'd0, 1'b0};
    words.push_back(one);
    // Released sync waits leave the queue; at most one command goes out.
    while (!pending_q && fill_q > 0) begin
      hw = fifo_mem[head_q][CMD_WORDS - 1][63:32];
      if (hw[31:28] == DT_SYNC && hw[23:16] == OP_WAIT) begin
        if (!flag_q[hw[15:8]]) break;
        flag_q[hw[15:8]] = 0;
        head_q++;
        fill_q--;
        continue;
      end
      for (int w = 0; w < CMD_WORDS; w++) begin
        one = '{1'b1, ST_OK, 4'd0, {TARGET_HIGH, hw[31:28], hw[27:24], 20'd0},
                3'(w), fifo_mem[head_q][w], 1'b0};
        words.push_back(one);
      end
      pending_q = 1;
      cmds_sent++;
      break;
    end
    foreach (words[k]) begin
      words[k].count = 4'(fill_q);
      words[k].last = (k == words.size() - 1);
      expected_words.push_back(words[k]);
    end
  endtask

  task automatic send_word(row_t r);
    if (burst_left == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = r.rt;
    s_tdata  = {3'b000, r.data, r.size, r.off, r.port};
    predict_step(r);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Receiver stalls in phases: always ready, about half ready, or mostly stalled.
  int stall_mode = 0;
  int stall_len = 0;
  always @(negedge clk) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_len = $urandom_range(5, 40);
    end
    stall_len--;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[2:0], m_tdata[6:3], m_tdata[38:7], m_tdata[41:39],
              m_tdata[105:42], m_tlast};
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word: %p", got);
      end else begin
        want = expected_words[0];
        expected_words.delete(0);
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic logic [31:0] random_header();
    if ($urandom_range(0, 2) == 0)
      return {DT_SYNC, 4'($urandom), OP_WAIT,
              ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3)), 8'($urandom)};
    return $urandom;
  endfunction

  row_t directed[] = '{
    '{RT_TICK, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_OK},
    '{RT_CPU,  2'd0, 7'd64,  4'd1,  64'd1, 1, ST_EMPTY},
    '{RT_RESP, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_EMPTY},
    '{RT_CPU,  2'd1, 7'd0,   4'd0,  64'd5, 1, ST_SIZE},
    '{RT_CPU,  2'd2, 7'd0,   4'd15, 64'd5, 1, ST_SIZE},
    '{RT_SYNC, 2'd0, 7'd0,   4'd3,  64'h0001_0000, 1, ST_SIZE},
    '{RT_CPU,  2'd0, 7'd127, 4'd2,  64'd0, 1, ST_BAD_WIN},
    '{RT_CPU,  2'd0, 7'd60,  4'd8,  64'd0, 1, ST_BAD_WIN},
    '{RT_CPU,  2'd0, 7'd64,  4'd1,  64'd2, 1, ST_BAD_CTRL},
    '{RT_SYNC, 2'd0, 7'd0,   4'd4,  64'h0002_0300, 1, ST_BAD_SYNC},
    '{RT_CPU,  2'd3, 7'd60,  4'd4,  64'h3500_0000, 1, ST_OK},
    '{RT_CPU,  2'd3, 7'd0,   4'd8,  '1, 1, ST_OK},
    '{RT_CPU,  2'd3, 7'd64,  4'd8,  64'd0, 0, ST_OK},
    '{RT_CPU,  2'd0, 7'd64,  4'd8,  64'd0, 1, ST_BLOCKED},
    '{RT_TICK, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_OK},
    '{RT_CPU,  2'd1, 7'd60,  4'd4,  64'h1000_0700, 1, ST_OK},
    '{RT_CPU,  2'd1, 7'd127, 4'd1,  64'hFF00, 0, ST_OK},
    '{RT_RESP, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_OK},
    '{RT_SYNC, 2'd0, 7'd0,   4'd8,  64'hFFFF_FFFF_0001_0700, 1, ST_OK},
    '{RT_TICK, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_OK},
    '{RT_CPU,  2'd2, 7'd63,  4'd1,  64'hAB, 1, ST_OK},
    '{RT_CPU,  2'd2, 7'd100, 4'd2,  64'h10000, 0, ST_OK},
    '{RT_CPU,  2'd0, 7'd80,  4'd1,  64'h1, 0, ST_OK},
    '{RT_RESP, 2'd0, 7'd0,   4'd1,  64'd0, 1, ST_EMPTY}
  };

  initial begin
    row_t r;
    int   pick;
    int   wait_cycles;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    errors = 0;
    items_sent = 0;
    words_seen = 0;
    cmds_sent = 0;
    burst_left = 0;
    head_q = '0;
    tail_q = '0;
    fill_q = 0;
    gate_q = 0;
    pending_q = 0;
    foreach (stage_mem[p, w]) stage_mem[p][w] = '0;
    foreach (flag_q[i]) flag_q[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_word(directed[i]);

    for (int n = 0; n < 156; n++) begin
      r = '{RT_CPU, 2'($urandom), 7'd0, 4'd1, {$urandom, $urandom}, 0, ST_OK};
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        r.off = 7'($urandom_range(0, 63));
        r.size = 4'($urandom_range(1, (64 - r.off < 8) ? 64 - r.off : 8));
      end else if (pick < 30) begin
        r.off = 7'd60;
        r.size = 4'd4;
        r.data = {32'($urandom), random_header()};
      end else if (pick < 42) begin
        r.off = 7'($urandom_range(64, 120));
        r.size = 4'($urandom_range(1, 8));
        r.data = r.data << (8 * r.size);
      end else if (pick < 50) begin
        r.off = 7'($urandom_range(64, 120));
        r.size = 4'($urandom_range(1, 8));
        r.data = (r.data << (8 * r.size)) | 64'd1;
      end else if (pick < 62) begin
        r.rt = RT_TICK;
      end else if (pick < 76) begin
        r.rt = RT_RESP;
      end else if (pick < 88) begin
        r.rt = RT_SYNC;
        r.size = 4'($urandom_range(4, 8));
        r.data[23:16] = OP_SET;
        r.data[15:8] = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
      end else begin
        r.rt = 2'($urandom);
        r.off = 7'($urandom);
        r.size = 4'($urandom);
      end
      send_word(r);
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    wait_cycles = 0;
    while (expected_words.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    errors += expected_words.size();

    $display("Sent %0d input words; checked %0d output words, %0d commands dispatched.",
             items_sent, words_seen, cmds_sent);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
